@@ src/dfhc_pkg.sv @@
// Shared types and constants for the decode forwarding hazard check block
`timescale 1ns / 1ps

package dfhc_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int REG_WIDTH  = 5;

   localparam logic [1:0] MODE_LOAD_SLOT   = 2'd0;
   localparam logic [1:0] MODE_CHECK       = 2'd1;
   localparam logic [1:0] MODE_CLEAR_STALL = 2'd2;

   typedef logic [REG_WIDTH-1:0] reg_num_type;

   typedef struct packed {
      logic fwd_rs;
      logic fwd_rs_depth;
      logic fwd_rt;
      logic fwd_rt_depth;
      logic delayed_rs;
      logic delayed_rs_depth;
      logic delayed_rt;
      logic delayed_rt_depth;
      logic load_use_stall;
      logic skipped;
   } hazard_result_type;

endpackage

@@ src/dfhc_req_if.sv @@
// Request channel interface: valid/ready plus one decoded-instruction transaction
`timescale 1ns / 1ps

interface dfhc_req_if #(parameter int ORDER_WIDTH = 16);
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic [1:0]               slot;
   dfhc_pkg::reg_num_type    dest_reg;
   logic [ORDER_WIDTH-1:0]   order;
   logic                     is_load;
   dfhc_pkg::reg_num_type    src_rs;
   dfhc_pkg::reg_num_type    src_rt;
   logic                     is_store;
   logic                     recent_stall_two;
   logic                     first_in_bundle;
   logic                     front_is_nop;

   modport source (
      output valid, mode, slot, dest_reg, order, is_load, src_rs, src_rt,
             is_store, recent_stall_two, first_in_bundle, front_is_nop,
      input  ready
   );

   modport sink (
      input  valid, mode, slot, dest_reg, order, is_load, src_rs, src_rt,
             is_store, recent_stall_two, first_in_bundle, front_is_nop,
      output ready
   );
endinterface

@@ src/dfhc_rsp_if.sv @@
// Response channel interface: valid/ready plus forwarding and stall result fields
`timescale 1ns / 1ps

interface dfhc_rsp_if;
   logic valid;
   logic ready;
   logic fwd_rs;
   logic fwd_rs_depth;
   logic fwd_rt;
   logic fwd_rt_depth;
   logic delayed_rs;
   logic delayed_rs_depth;
   logic delayed_rt;
   logic delayed_rt_depth;
   logic load_use_stall;
   logic skipped;

   modport source (
      output valid, fwd_rs, fwd_rs_depth, fwd_rt, fwd_rt_depth, delayed_rs,
             delayed_rs_depth, delayed_rt, delayed_rt_depth, load_use_stall,
             skipped,
      input  ready
   );

   modport sink (
      input  valid, fwd_rs, fwd_rs_depth, fwd_rt, fwd_rt_depth, delayed_rs,
             delayed_rs_depth, delayed_rt, delayed_rt_depth, load_use_stall,
             skipped,
      output ready
   );
endinterface

@@ src/dfhc_pair_match.sv @@
// Source register compare against a pair of hazard slots; the later slot wins
`timescale 1ns / 1ps

module dfhc_pair_match #(
   parameter int ORDER_WIDTH = 16
) (
   input  dfhc_pkg::reg_num_type  src,
   input  logic [ORDER_WIDTH-1:0] order,
   input  dfhc_pkg::reg_num_type  dest_0,
   input  dfhc_pkg::reg_num_type  dest_1,
   input  logic [ORDER_WIDTH-1:0] order_0,
   input  logic [ORDER_WIDTH-1:0] order_1,
   output logic                   hit,
   output logic                   depth
);

   logic match_0;
   logic match_1;

   assign match_0 = (src == dest_0);
   assign match_1 = (src == dest_1);

   always_comb begin
      priority if (match_1) begin
         hit = (order > order_1);
      end else if (match_0) begin
         hit = (order > order_0);
      end else begin
         hit = 1'b0;
      end
   end

   // depth only meaningful with a hit; zero otherwise
   assign depth = hit & match_1;

endmodule

@@ src/dfhc_hazard_eval.sv @@
// Combinational hazard evaluation for one transaction: forwards, stall and suppression
`timescale 1ns / 1ps

module dfhc_hazard_eval #(
   parameter int ORDER_WIDTH = 16
) (
   input  logic [1:0]                  mode,
   input  dfhc_pkg::reg_num_type       src_rs,
   input  dfhc_pkg::reg_num_type       src_rt,
   input  logic [ORDER_WIDTH-1:0]      order,
   input  logic                        is_store,
   input  logic                        recent_stall_two,
   input  logic                        first_in_bundle,
   input  logic                        front_is_nop,
   input  dfhc_pkg::reg_num_type       slot_dest  [dfhc_pkg::SLOT_COUNT],
   input  logic [ORDER_WIDTH-1:0]      slot_order [dfhc_pkg::SLOT_COUNT],
   input  logic [dfhc_pkg::SLOT_COUNT-1:0] slot_is_load,
   input  logic                        stall_flag,
   input  logic                        bundle_suppressed,
   output dfhc_pkg::hazard_result_type result,
   output logic                        stall_next,
   output logic                        suppressed_next
);

   dfhc_pkg::reg_num_type  near_dest_0;
   dfhc_pkg::reg_num_type  near_dest_1;
   logic [ORDER_WIDTH-1:0] near_order_0;
   logic [ORDER_WIDTH-1:0] near_order_1;
   logic                   frs_hit;
   logic                   frs_depth;
   logic                   frt_hit;
   logic                   frt_depth;
   logic                   drs_hit;
   logic                   drs_depth;
   logic                   drt_hit;
   logic                   drt_depth;
   logic                   is_check;
   logic                   suppressed;
   logic                   active;
   logic                   rs_load;
   logic                   rt_load;

   // normal forwarding pair: slots 0/1 when recent_stall_two is set, else slots 2/3
   assign near_dest_0  = recent_stall_two ? slot_dest[0]  : slot_dest[2];
   assign near_dest_1  = recent_stall_two ? slot_dest[1]  : slot_dest[3];
   assign near_order_0 = recent_stall_two ? slot_order[0] : slot_order[2];
   assign near_order_1 = recent_stall_two ? slot_order[1] : slot_order[3];

   dfhc_pair_match #(.ORDER_WIDTH(ORDER_WIDTH)) u_fwd_rs (
      .src(src_rs), .order(order),
      .dest_0(near_dest_0), .dest_1(near_dest_1),
      .order_0(near_order_0), .order_1(near_order_1),
      .hit(frs_hit), .depth(frs_depth)
   );

   dfhc_pair_match #(.ORDER_WIDTH(ORDER_WIDTH)) u_fwd_rt (
      .src(src_rt), .order(order),
      .dest_0(near_dest_0), .dest_1(near_dest_1),
      .order_0(near_order_0), .order_1(near_order_1),
      .hit(frt_hit), .depth(frt_depth)
   );

   dfhc_pair_match #(.ORDER_WIDTH(ORDER_WIDTH)) u_dly_rs (
      .src(src_rs), .order(order),
      .dest_0(slot_dest[0]), .dest_1(slot_dest[1]),
      .order_0(slot_order[0]), .order_1(slot_order[1]),
      .hit(drs_hit), .depth(drs_depth)
   );

   dfhc_pair_match #(.ORDER_WIDTH(ORDER_WIDTH)) u_dly_rt (
      .src(src_rt), .order(order),
      .dest_0(slot_dest[0]), .dest_1(slot_dest[1]),
      .order_0(slot_order[0]), .order_1(slot_order[1]),
      .hit(drt_hit), .depth(drt_depth)
   );

   assign is_check = (mode == dfhc_pkg::MODE_CHECK);

   always_comb begin
      suppressed_next = bundle_suppressed;
      if (is_check && first_in_bundle) begin
         suppressed_next = stall_flag | front_is_nop;
      end
   end

   assign suppressed = suppressed_next;
   assign active     = is_check & ~suppressed;

   assign rs_load = frs_depth ? slot_is_load[3] : slot_is_load[2];
   assign rt_load = frt_depth ? slot_is_load[3] : slot_is_load[2];

   always_comb begin
      stall_next = stall_flag;
      if (mode == dfhc_pkg::MODE_CLEAR_STALL) begin
         stall_next = 1'b0;
      end else if (active && !recent_stall_two) begin
         if (frs_hit && rs_load) begin
            stall_next = 1'b1;
         end
         if (frt_hit && rt_load) begin
            stall_next = is_store ? frs_hit : 1'b1;
         end
      end
   end

   always_comb begin
      result                  = '0;
      result.fwd_rs           = active & frs_hit;
      result.fwd_rs_depth     = active & frs_depth;
      result.fwd_rt           = active & frt_hit;
      result.fwd_rt_depth     = active & frt_depth;
      result.delayed_rs       = active & ~recent_stall_two & drs_hit;
      result.delayed_rs_depth = active & ~recent_stall_two & drs_depth;
      result.delayed_rt       = active & ~recent_stall_two & drt_hit;
      result.delayed_rt_depth = active & ~recent_stall_two & drt_depth;
      result.load_use_stall   = stall_next;
      result.skipped          = is_check & suppressed;
   end

endmodule

@@ src/decode_forwarding_hazard_check_core.sv @@
// Top level of the decode forwarding and load-use hazard check block
//
//  channel | dir | handshake        | transaction
//  --------+-----+------------------+--------------------------------------------
//  req     | in  | req.valid/ready  | slot load, instruction check or stall clear
//  rsp     | out | rsp.valid/ready  | forward flags, depths, stall flag, skipped
//
//  One transaction per cycle sustained while rsp is ready; a response passes through
//  the input register, then the comparison logic into the result register.
//  Hazard slots and flags update as a transaction moves into the result register,
//  so the next transaction in line already sees them.
//  Synchronous reset clears slots, stall and suppression flags and both valids.
//  A stalled rsp holds the result; req keeps accepting while the input register
//  is empty or the result register drains in the same cycle.
`timescale 1ns / 1ps

module decode_forwarding_hazard_check_core #(
   parameter int ORDER_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   dfhc_req_if.sink  req,
   dfhc_rsp_if.source rsp
);

   logic                        advance;
   logic                        accept;
   logic                        fire;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [1:0]                  in_mode_ff;
   logic [1:0]                  in_slot_ff;
   dfhc_pkg::reg_num_type       in_dest_ff;
   logic [ORDER_WIDTH-1:0]      in_order_ff;
   logic                        in_is_load_ff;
   dfhc_pkg::reg_num_type       in_rs_ff;
   dfhc_pkg::reg_num_type       in_rt_ff;
   logic                        in_is_store_ff;
   logic                        in_two_ff;
   logic                        in_first_ff;
   logic                        in_nop_ff;

   dfhc_pkg::reg_num_type       slot_dest_ff  [dfhc_pkg::SLOT_COUNT];
   logic [ORDER_WIDTH-1:0]      slot_order_ff [dfhc_pkg::SLOT_COUNT];
   logic [dfhc_pkg::SLOT_COUNT-1:0] slot_is_load_ff;
   logic                        stall_ff;
   logic                        stall_in;
   logic                        suppressed_ff;
   logic                        suppressed_in;

   dfhc_pkg::hazard_result_type result_in;
   dfhc_pkg::hazard_result_type result_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;

   assign advance   = ~rsp_valid_ff | rsp.ready;
   assign req.ready = ~in_valid_ff | advance;
   assign accept    = req.valid & req.ready;
   assign fire      = in_valid_ff & advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff     <= req.mode;
         in_slot_ff     <= req.slot;
         in_dest_ff     <= req.dest_reg;
         in_order_ff    <= req.order;
         in_is_load_ff  <= req.is_load;
         in_rs_ff       <= req.src_rs;
         in_rt_ff       <= req.src_rt;
         in_is_store_ff <= req.is_store;
         in_two_ff      <= req.recent_stall_two;
         in_first_ff    <= req.first_in_bundle;
         in_nop_ff      <= req.front_is_nop;
      end
   end

   dfhc_hazard_eval #(.ORDER_WIDTH(ORDER_WIDTH)) u_eval (
      .mode              (in_mode_ff),
      .src_rs            (in_rs_ff),
      .src_rt            (in_rt_ff),
      .order             (in_order_ff),
      .is_store          (in_is_store_ff),
      .recent_stall_two  (in_two_ff),
      .first_in_bundle   (in_first_ff),
      .front_is_nop      (in_nop_ff),
      .slot_dest         (slot_dest_ff),
      .slot_order        (slot_order_ff),
      .slot_is_load      (slot_is_load_ff),
      .stall_flag        (stall_ff),
      .bundle_suppressed (suppressed_ff),
      .result            (result_in),
      .stall_next        (stall_in),
      .suppressed_next   (suppressed_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dfhc_pkg::SLOT_COUNT; i++) begin
            slot_dest_ff[i]  <= '0;
            slot_order_ff[i] <= '0;
         end
         slot_is_load_ff <= '0;
         stall_ff        <= 1'b0;
         suppressed_ff   <= 1'b0;
      end else if (fire) begin
         if (in_mode_ff == dfhc_pkg::MODE_LOAD_SLOT) begin
            slot_dest_ff[in_slot_ff]    <= in_dest_ff;
            slot_order_ff[in_slot_ff]   <= in_order_ff;
            slot_is_load_ff[in_slot_ff] <= in_is_load_ff;
         end
         stall_ff      <= stall_in;
         suppressed_ff <= suppressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.fwd_rs           = result_ff.fwd_rs;
   assign rsp.fwd_rs_depth     = result_ff.fwd_rs_depth;
   assign rsp.fwd_rt           = result_ff.fwd_rt;
   assign rsp.fwd_rt_depth     = result_ff.fwd_rt_depth;
   assign rsp.delayed_rs       = result_ff.delayed_rs;
   assign rsp.delayed_rs_depth = result_ff.delayed_rs_depth;
   assign rsp.delayed_rt       = result_ff.delayed_rt;
   assign rsp.delayed_rt_depth = result_ff.delayed_rt_depth;
   assign rsp.load_use_stall   = result_ff.load_use_stall;
   assign rsp.skipped          = result_ff.skipped;

endmodule

@@ verif/dfhc_hazard_checker.sv @@
// Checker: predicts each hazard result from accepted requests and compares responses
`timescale 1ns / 1ps

module dfhc_hazard_checker #(
   parameter int ORDER_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   dfhc_req_if  req,
   dfhc_rsp_if  rsp,
   output int   mismatch_count,
   output int   outstanding
);

   dfhc_pkg::reg_num_type       slot_dest  [dfhc_pkg::SLOT_COUNT];
   logic [ORDER_WIDTH-1:0]      slot_order [dfhc_pkg::SLOT_COUNT];
   logic                        slot_load  [dfhc_pkg::SLOT_COUNT];
   logic                        stall_held;
   logic                        bundle_off;
   dfhc_pkg::hazard_result_type expected_hazards [$];

   // indexed by bit position in hazard_result_type
   string field_name [10] = '{"skipped", "load_use_stall", "delayed_rt_depth", "delayed_rt",
                              "delayed_rs_depth", "delayed_rs", "fwd_rt_depth", "fwd_rt",
                              "fwd_rs_depth", "fwd_rs"};

   // later slot of the pair wins; a match that is not older clears the flag
   function automatic void match_slot_pair(input dfhc_pkg::reg_num_type src,
                                           input logic [ORDER_WIDTH-1:0] ord,
                                           input int base, inout logic hit,
                                           inout logic depth);
      for (int d = 0; d < 2; d++) begin
         if (src == slot_dest[base + d]) begin
            if (ord > slot_order[base + d]) begin
               hit   = 1'b1;
               depth = (d == 1);
            end else begin
               hit = 1'b0;
            end
         end
      end
   endfunction

   function automatic dfhc_pkg::hazard_result_type predict_hazard();
      dfhc_pkg::hazard_result_type res;
      logic frs, frt, drs, drt;
      logic frs_d, frt_d, drs_d, drt_d;
      res = '0;
      {frs, frt, drs, drt} = '0;
      {frs_d, frt_d, drs_d, drt_d} = '0;
      unique case (req.mode)
         dfhc_pkg::MODE_LOAD_SLOT: begin
            slot_dest[req.slot]  = req.dest_reg;
            slot_order[req.slot] = req.order;
            slot_load[req.slot]  = req.is_load;
         end
         dfhc_pkg::MODE_CLEAR_STALL: stall_held = 1'b0;
         dfhc_pkg::MODE_CHECK: begin
            if (req.first_in_bundle)
               bundle_off = stall_held || req.front_is_nop;
            if (bundle_off) begin
               res.skipped = 1'b1;
            end else if (req.recent_stall_two) begin
               match_slot_pair(req.src_rs, req.order, 0, frs, frs_d);
               match_slot_pair(req.src_rt, req.order, 0, frt, frt_d);
            end else begin
               match_slot_pair(req.src_rs, req.order, 2, frs, frs_d);
               match_slot_pair(req.src_rt, req.order, 2, frt, frt_d);
               if (frs && slot_load[2 + frs_d])
                  stall_held = 1'b1;
               if (frt && slot_load[2 + frt_d])
                  stall_held = req.is_store ? frs : 1'b1;
               match_slot_pair(req.src_rs, req.order, 0, drs, drs_d);
               match_slot_pair(req.src_rt, req.order, 0, drt, drt_d);
            end
         end
         default: ;
      endcase
      res.fwd_rs           = frs;
      res.fwd_rs_depth     = frs & frs_d;
      res.fwd_rt           = frt;
      res.fwd_rt_depth     = frt & frt_d;
      res.delayed_rs       = drs;
      res.delayed_rs_depth = drs & drs_d;
      res.delayed_rt       = drt;
      res.delayed_rt_depth = drt & drt_d;
      res.load_use_stall   = stall_held;
      return res;
   endfunction

   always @(posedge clock) begin
      dfhc_pkg::hazard_result_type seen;
      dfhc_pkg::hazard_result_type want;
      if (reset) begin
         for (int i = 0; i < dfhc_pkg::SLOT_COUNT; i++) begin
            slot_dest[i]  = '0;
            slot_order[i] = '0;
            slot_load[i]  = 1'b0;
         end
         stall_held     = 1'b0;
         bundle_off     = 1'b0;
         mismatch_count = 0;
         expected_hazards.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen.fwd_rs           = rsp.fwd_rs;
            seen.fwd_rs_depth     = rsp.fwd_rs_depth;
            seen.fwd_rt           = rsp.fwd_rt;
            seen.fwd_rt_depth     = rsp.fwd_rt_depth;
            seen.delayed_rs       = rsp.delayed_rs;
            seen.delayed_rs_depth = rsp.delayed_rs_depth;
            seen.delayed_rt       = rsp.delayed_rt;
            seen.delayed_rt_depth = rsp.delayed_rt_depth;
            seen.load_use_stall   = rsp.load_use_stall;
            seen.skipped          = rsp.skipped;
            if (expected_hazards.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected rsp transaction, expected none, actual %b",
                        $time, seen);
            end else begin
               want = expected_hazards.pop_front();
               for (int b = 9; b >= 0; b--) begin
                  if (want[b] !== seen[b]) begin
                     mismatch_count++;
                     $display("%0t: %s mismatch, expected %0b actual %0b",
                              $time, field_name[b], want[b], seen[b]);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            expected_hazards.push_back(predict_hazard());
      end
      outstanding = expected_hazards.size();
   end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: reset, stimulus, response back-pressure, watchdog and verdict
`timescale 1ns / 1ps

module tb_top;

   localparam int         ORDER_WIDTH = 16;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         IDLE_LIMIT  = 2000;
   localparam int         LONG_HOLD   = 80;

   typedef struct {
      logic [1:0]             mode;
      logic [1:0]             slot;
      dfhc_pkg::reg_num_type  dest_reg;
      logic [ORDER_WIDTH-1:0] order;
      logic                   is_load;
      dfhc_pkg::reg_num_type  src_rs;
      dfhc_pkg::reg_num_type  src_rt;
      logic                   is_store;
      logic                   recent_stall_two;
      logic                   first_in_bundle;
      logic                   front_is_nop;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   outstanding;
   int   idle_cycles = 0;
   bit   calm = 1'b0;
   bit   hold_request = 1'b0;
   bit   hold_active = 1'b0;

   dfhc_req_if #(.ORDER_WIDTH(ORDER_WIDTH)) req_bus ();
   dfhc_rsp_if rsp_bus ();

   decode_forwarding_hazard_check_core #(.ORDER_WIDTH(ORDER_WIDTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   dfhc_hazard_checker #(.ORDER_WIDTH(ORDER_WIDTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   function automatic req_item_type slot_item(input int slot, input int dest,
                                              input int order, input bit load);
      req_item_type it;
      it = '{default: '0};
      it.mode     = dfhc_pkg::MODE_LOAD_SLOT;
      it.slot     = 2'(slot);
      it.dest_reg = dfhc_pkg::reg_num_type'(dest);
      it.order    = ORDER_WIDTH'(order);
      it.is_load  = load;
      return it;
   endfunction

   function automatic req_item_type check_item(input int rs, input int rt, input int order,
                                               input bit store, input bit two,
                                               input bit first, input bit nop);
      req_item_type it;
      it = '{default: '0};
      it.mode             = dfhc_pkg::MODE_CHECK;
      it.src_rs           = dfhc_pkg::reg_num_type'(rs);
      it.src_rt           = dfhc_pkg::reg_num_type'(rt);
      it.order            = ORDER_WIDTH'(order);
      it.is_store         = store;
      it.recent_stall_two = two;
      it.first_in_bundle  = first;
      it.front_is_nop     = nop;
      return it;
   endfunction

   function automatic req_item_type mode_item(input logic [1:0] mode);
      req_item_type it;
      it = '{default: '0};
      it.mode = mode;
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it.mode             = 2'($urandom_range(0, 3));
      it.slot             = 2'($urandom_range(0, 3));
      it.dest_reg         = dfhc_pkg::reg_num_type'($urandom_range(0, 31));
      it.order            = ORDER_WIDTH'($urandom);
      it.is_load          = 1'($urandom_range(0, 1));
      it.src_rs           = dfhc_pkg::reg_num_type'($urandom_range(0, 31));
      it.src_rt           = dfhc_pkg::reg_num_type'($urandom_range(0, 31));
      it.is_store         = 1'($urandom_range(0, 1));
      it.recent_stall_two = 1'($urandom_range(0, 1));
      it.first_in_bundle  = 1'($urandom_range(0, 1));
      it.front_is_nop     = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // small register pool so slots and sources collide often
   function automatic int pick_reg();
      return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
   endfunction

   // called and returns at a falling edge; valid stays high unless a gap was taken
   task automatic send_item(input req_item_type it, input bit allow_gap);
      req_bus.valid            <= 1'b1;
      req_bus.mode             <= it.mode;
      req_bus.slot             <= it.slot;
      req_bus.dest_reg         <= it.dest_reg;
      req_bus.order            <= it.order;
      req_bus.is_load          <= it.is_load;
      req_bus.src_rs           <= it.src_rs;
      req_bus.src_rt           <= it.src_rt;
      req_bus.is_store         <= it.is_store;
      req_bus.recent_stall_two <= it.recent_stall_two;
      req_bus.first_in_bundle  <= it.first_in_bundle;
      req_bus.front_is_nop     <= it.front_is_nop;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (allow_gap && !calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   // slot loads followed by a bundle of checks around the same program order, at times then a stall clear
   task automatic run_sequence(input bit allow_gap, inout int sent);
      logic [ORDER_WIDTH-1:0] base;
      int                     loads;
      int                     checks;
      base   = ORDER_WIDTH'($urandom);
      loads  = $urandom_range(1, 4);
      checks = $urandom_range(1, 4);
      for (int i = 0; i < loads; i++) begin
         send_item(slot_item($urandom_range(0, 3), pick_reg(),
                             int'(base) + int'($urandom_range(0, 6)),
                             $urandom_range(0, 4) < 2), allow_gap);
         sent++;
      end
      for (int i = 0; i < checks; i++) begin
         send_item(check_item(pick_reg(), pick_reg(),
                              int'(base) + int'($urandom_range(0, 8)),
                              $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0,
                              (i == 0) || ($urandom_range(0, 4) == 0),
                              $urandom_range(0, 9) == 0), allow_gap);
         sent++;
      end
      if ($urandom_range(0, 9) < 4) begin
         send_item(mode_item(dfhc_pkg::MODE_CLEAR_STALL), allow_gap);
         sent++;
      end
   endtask

   task automatic run_random(input int target, input bit allow_gap, inout int sent);
      req_item_type it;
      while (sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            run_sequence(allow_gap, sent);
         end else begin
            it = noise_item();
            send_item(it, allow_gap);
            if (it.mode != MODE_UNUSED)
               sent++;
         end
      end
   endtask

   initial begin
      int sent;
      req_item_type wide;
      sent = 0;
      req_bus.valid            <= 1'b0;
      req_bus.mode             <= dfhc_pkg::MODE_LOAD_SLOT;
      req_bus.slot             <= '0;
      req_bus.dest_reg         <= '0;
      req_bus.order            <= '0;
      req_bus.is_load          <= 1'b0;
      req_bus.src_rs           <= '0;
      req_bus.src_rt           <= '0;
      req_bus.is_store         <= 1'b0;
      req_bus.recent_stall_two <= 1'b0;
      req_bus.first_in_bundle  <= 1'b0;
      req_bus.front_is_nop     <= 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(check_item(0, 0, 0, 0, 0, 1, 0), 1);
      send_item(slot_item(2, 5, 100, 0), 1);
      send_item(slot_item(3, 5, 200, 1), 1);
      send_item(slot_item(0, 7, 50, 0), 1);
      send_item(slot_item(1, 31, 'hFFFF, 1), 1);
      send_item(check_item(5, 7, 300, 0, 0, 1, 0), 1);
      send_item(check_item(5, 31, 150, 0, 0, 0, 0), 1);
      send_item(check_item(1, 2, 400, 0, 0, 1, 0), 1);
      send_item(check_item(5, 7, 400, 0, 0, 0, 0), 1);
      send_item(mode_item(dfhc_pkg::MODE_CLEAR_STALL), 1);
      send_item(check_item(0, 0, 0, 0, 0, 1, 1), 1);
      send_item(check_item(7, 31, 'hFFFF, 0, 1, 1, 0), 1);
      send_item(slot_item(2, 9, 10, 1), 1);
      send_item(slot_item(3, 4, 10, 0), 1);
      send_item(check_item(9, 3, 20, 0, 0, 1, 0), 1);
      send_item(check_item(3, 9, 20, 1, 0, 0, 0), 1);
      send_item(check_item(4, 9, 20, 1, 0, 1, 0), 1);
      wide = check_item(31, 31, 'hFFFF, 1, 1, 1, 1);
      wide.mode     = MODE_UNUSED;
      wide.slot     = 2'b11;
      wide.dest_reg = 5'd31;
      wide.is_load  = 1'b1;
      send_item(wide, 1);
      send_item(mode_item(dfhc_pkg::MODE_CLEAR_STALL), 1);
      send_item(slot_item(3, 31, 'hFFFF, 1), 1);
      send_item(check_item(31, 31, 'hFFFF, 1, 0, 1, 0), 1);
      send_item(slot_item(2, 0, 0, 0), 1);
      send_item(check_item(0, 0, 1, 0, 0, 1, 0), 1);

      run_random(400, 1, sent);

      // stall the response side for a long stretch while requests keep coming
      req_bus.valid <= 1'b0;
      hold_request = 1'b1;
      while (!hold_active) @(negedge clock);
      run_random(430, 0, sent);

      // let everything drain before continuing
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);

      run_random(720, 1, sent);
      calm = 1'b1;
      run_random(850, 1, sent);

      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("** decode_forwarding_hazard_check_core: PASSED **");
      else
         $display("** decode_forwarding_hazard_check_core: FAILED **");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            hold_active  = 1'b1;
            hold_request = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_active = 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** decode_forwarding_hazard_check_core: FAILED **");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

endmodule
